// ===== src/tmp_pkg.sv =====
package tmp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_WIDTH = 32;
	localparam int MAG_W = 62;
	localparam int MQ_W = 64 - FRAC_BITS;
	localparam int DIV_W = 64 + FRAC_BITS;
	localparam logic [MAG_W-1:0] CEIL_MAG = '1;

	typedef enum logic [1:0] {
		REG_MAX_VELOCITY = 2'd0,
		REG_ACCEL_RATE = 2'd1,
		REG_DECEL_RATE = 2'd2,
		REG_TARGET_DISTANCE = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_ACCEL = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [30:0] v;
		logic [30:0] a;
		logic [31:0] d;
		logic [31:0] s;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0] aet;
		logic [MAG_W-1:0] cet;
		logic [MAG_W-1:0] det;
		logic [31:0] aep;
		logic [31:0] cep;
		logic [30:0] peak;
	} plan_t;

	function automatic logic [MAG_W-1:0] q_mul(input logic [127:0] prod);
		logic [127:0] p;
		p = prod >> FRAC_BITS;
		return (p > 128'(CEIL_MAG)) ? CEIL_MAG : p[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] q_div(input logic [DIV_W-1:0] quo);
		return (|quo[DIV_W-1:MAG_W]) ? CEIL_MAG : quo[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] sat_add(input logic [MAG_W-1:0] x,
		input logic [MAG_W-1:0] y);
		logic [MAG_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[MAG_W] ? CEIL_MAG : s[MAG_W-1:0];
	endfunction

endpackage

// ===== src/tmp_plan.sv =====
module tmp_plan (
	input logic clk,
	input logic arst_n,
	input logic restart,
	input tmp_pkg::cfg_t cfg,
	output tmp_pkg::plan_t plan,
	output logic busy
);

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_DT1 = 16'h0002,
		S_DT3 = 16'h0004,
		S_TAIL = 16'h0008,
		S_P2T = 16'h0010,
		S_AEP = 16'h0020,
		S_CRS = 16'h0040,
		S_HMUL = 16'h0080,
		S_HDIV = 16'h0100,
		S_SMUL = 16'h0200,
		S_SQRT = 16'h0400,
		S_AET = 16'h0800,
		S_T1 = 16'h1000,
		S_AEPT = 16'h2000,
		S_DT3T = 16'h4000,
		S_CLAMP = 16'h8000
	} state_t;

	localparam int MW = tmp_pkg::MAG_W;
	localparam int DW = tmp_pkg::DIV_W;
	localparam int FB = tmp_pkg::FRAC_BITS;

	state_t state_q;
	logic wait_q;
	logic go;
	logic [MW-1:0] dt1_q, dt3_q, tail_q, p2t_q, aet_q, cet_q, det_q, aep_q, cep_q;
	logic [63:0] tmp_q;
	logic [30:0] peak_q;
	logic [MW-1:0] s_mag, tail_n, s_minus;

	logic mul_go, mul_run_q, mul_done;
	logic [63:0] mul_x, mul_y, mul_a_q, mul_b_q;
	logic [127:0] mul_acc_q;
	logic [6:0] mul_cnt_q;
	logic [64:0] mul_sum;

	logic div_go, div_run_q, div_done;
	logic [DW-1:0] div_n, div_num_q;
	logic [32:0] div_d, div_den_q, div_rem_q;
	logic [33:0] div_r2, div_diff;
	logic [6:0] div_cnt_q;

	logic sqrt_go, sqrt_run_q, sqrt_done;
	logic [63:0] sqrt_x_q;
	logic [32:0] sqrt_rem_q;
	logic [31:0] sqrt_root_q;
	logic [34:0] sqrt_r2, sqrt_trial, sqrt_diff;
	logic [5:0] sqrt_cnt_q;
	logic [31:0] pk_n;

	assign s_mag = MW'(cfg.s);
	assign go = (state_q != S_IDLE) && (state_q != S_CLAMP) && !wait_q && !restart;
	assign tail_n = tmp_pkg::q_mul(mul_acc_q) >> 1;
	assign s_minus = s_mag - tail_q;
	assign pk_n = (sqrt_root_q > 32'(cfg.v)) ? 32'(cfg.v) : sqrt_root_q;

	always_comb begin
		mul_go = 1'b0;
		div_go = 1'b0;
		sqrt_go = 1'b0;
		mul_x = '0;
		mul_y = '0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			S_DT1: begin
				div_go = go;
				div_n = DW'({cfg.v, {FB{1'b0}}});
				div_d = 33'(cfg.a);
			end
			S_DT3: begin
				div_go = go;
				div_n = DW'({cfg.v, {FB{1'b0}}});
				div_d = 33'(cfg.d);
			end
			S_TAIL: begin
				mul_go = go;
				mul_x = 64'(dt1_q) + 64'(dt3_q);
				mul_y = 64'(cfg.v);
			end
			S_P2T: begin
				mul_go = go;
				mul_x = 64'(dt3_q);
				mul_y = 64'(cfg.v);
			end
			S_AEP: begin
				mul_go = go;
				mul_x = 64'(dt1_q);
				mul_y = 64'(cfg.v);
			end
			S_CRS: begin
				div_go = go;
				div_n = DW'({s_minus[31:0], {FB{1'b0}}});
				div_d = 33'(cfg.v);
			end
			S_HMUL: begin
				mul_go = go;
				mul_x = 64'(cfg.a);
				mul_y = 64'(cfg.d);
			end
			S_HDIV: begin
				div_go = go;
				div_n = DW'(tmp_q);
				div_d = 33'(cfg.a) + 33'(cfg.d);
			end
			S_SMUL: begin
				mul_go = go;
				mul_x = 64'(cfg.s);
				mul_y = tmp_q;
			end
			S_SQRT: begin
				sqrt_go = go;
			end
			S_AET: begin
				div_go = go;
				div_n = DW'({peak_q, {FB{1'b0}}});
				div_d = 33'(cfg.a);
			end
			S_T1: begin
				mul_go = go;
				mul_x = 64'(cfg.a);
				mul_y = 64'(aet_q);
			end
			S_AEPT: begin
				mul_go = go;
				mul_x = tmp_q;
				mul_y = 64'(aet_q);
			end
			S_DT3T: begin
				div_go = go;
				div_n = DW'({peak_q, {FB{1'b0}}});
				div_d = 33'(cfg.d);
			end
			default: ;
		endcase
	end

	// Shift-add multiplier, one bit of the second operand per cycle.
	assign mul_sum = {1'b0, mul_acc_q[127:64]} + (mul_b_q[0] ? {1'b0, mul_a_q} : 65'd0);
	assign mul_done = mul_run_q && (mul_cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q <= 1'b0;
			mul_cnt_q <= '0;
		end else if (restart) begin
			mul_run_q <= 1'b0;
		end else if (mul_go) begin
			mul_run_q <= 1'b1;
			mul_cnt_q <= 7'd64;
		end else if (mul_done) begin
			mul_run_q <= 1'b0;
		end else if (mul_run_q) begin
			mul_cnt_q <= mul_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_a_q <= mul_x;
			mul_b_q <= mul_y;
			mul_acc_q <= '0;
		end else if (mul_run_q && (mul_cnt_q != 7'd0)) begin
			mul_acc_q <= {mul_sum, mul_acc_q[63:1]};
			mul_b_q <= mul_b_q >> 1;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign div_r2 = {div_rem_q, div_num_q[DW-1]};
	assign div_diff = div_r2 - {1'b0, div_den_q};
	assign div_done = div_run_q && (div_cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (restart) begin
			div_run_q <= 1'b0;
		end else if (div_go) begin
			div_run_q <= 1'b1;
			div_cnt_q <= 7'(DW);
		end else if (div_done) begin
			div_run_q <= 1'b0;
		end else if (div_run_q) begin
			div_cnt_q <= div_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_num_q <= div_n;
			div_den_q <= div_d;
			div_rem_q <= '0;
		end else if (div_run_q && (div_cnt_q != 7'd0)) begin
			if (!div_diff[33]) begin
				div_rem_q <= div_diff[32:0];
				div_num_q <= {div_num_q[DW-2:0], 1'b1};
			end else begin
				div_rem_q <= div_r2[32:0];
				div_num_q <= {div_num_q[DW-2:0], 1'b0};
			end
		end
	end

	// Digit-by-digit square root, one result bit per cycle.
	assign sqrt_r2 = {sqrt_rem_q, sqrt_x_q[63:62]};
	assign sqrt_trial = {1'b0, sqrt_root_q, 2'b01};
	assign sqrt_diff = sqrt_r2 - sqrt_trial;
	assign sqrt_done = sqrt_run_q && (sqrt_cnt_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_run_q <= 1'b0;
			sqrt_cnt_q <= '0;
		end else if (restart) begin
			sqrt_run_q <= 1'b0;
		end else if (sqrt_go) begin
			sqrt_run_q <= 1'b1;
			sqrt_cnt_q <= 6'd32;
		end else if (sqrt_done) begin
			sqrt_run_q <= 1'b0;
		end else if (sqrt_run_q) begin
			sqrt_cnt_q <= sqrt_cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_go) begin
			sqrt_x_q <= tmp_q;
			sqrt_rem_q <= '0;
			sqrt_root_q <= '0;
		end else if (sqrt_run_q && (sqrt_cnt_q != 6'd0)) begin
			sqrt_x_q <= {sqrt_x_q[61:0], 2'b00};
			if (sqrt_r2 >= sqrt_trial) begin
				sqrt_rem_q <= sqrt_diff[32:0];
				sqrt_root_q <= {sqrt_root_q[30:0], 1'b1};
			end else begin
				sqrt_rem_q <= sqrt_r2[32:0];
				sqrt_root_q <= {sqrt_root_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_DT1;
			wait_q <= 1'b0;
			dt1_q <= '0;
			dt3_q <= '0;
			tail_q <= '0;
			p2t_q <= '0;
			aet_q <= '0;
			cet_q <= '0;
			det_q <= '0;
			aep_q <= '0;
			cep_q <= '0;
			peak_q <= '0;
			tmp_q <= '0;
		end else if (restart) begin
			state_q <= S_DT1;
			wait_q <= 1'b0;
		end else if (state_q == S_CLAMP) begin
			det_q <= tmp_pkg::sat_add(cet_q, dt3_q);
			if (aep_q > s_mag) begin
				aep_q <= s_mag;
			end
			if (cep_q > s_mag) begin
				cep_q <= s_mag;
			end
			state_q <= S_IDLE;
		end else if (state_q != S_IDLE) begin
			if (!wait_q) begin
				wait_q <= 1'b1;
			end else if (mul_done || div_done || sqrt_done) begin
				wait_q <= 1'b0;
				case (state_q)
					S_DT1: begin
						dt1_q <= tmp_pkg::q_div(div_num_q);
						state_q <= S_DT3;
					end
					S_DT3: begin
						dt3_q <= tmp_pkg::q_div(div_num_q);
						state_q <= S_TAIL;
					end
					S_TAIL: begin
						tail_q <= tail_n;
						state_q <= (s_mag > tail_n) ? S_P2T : S_HMUL;
					end
					S_P2T: begin
						p2t_q <= tmp_pkg::q_mul(mul_acc_q) >> 1;
						peak_q <= cfg.v;
						aet_q <= dt1_q;
						state_q <= S_AEP;
					end
					S_AEP: begin
						aep_q <= tmp_pkg::q_mul(mul_acc_q) >> 1;
						state_q <= S_CRS;
					end
					S_CRS: begin
						cet_q <= tmp_pkg::sat_add(dt1_q, tmp_pkg::q_div(div_num_q));
						cep_q <= (s_mag > p2t_q) ? s_mag - p2t_q : '0;
						state_q <= S_CLAMP;
					end
					S_HMUL: begin
						tmp_q <= mul_acc_q[63:0];
						state_q <= S_HDIV;
					end
					S_HDIV: begin
						tmp_q <= div_num_q[63:0];
						state_q <= S_SMUL;
					end
					S_SMUL: begin
						tmp_q <= {mul_acc_q[62:0], 1'b0};
						state_q <= S_SQRT;
					end
					S_SQRT: begin
						peak_q <= pk_n[30:0];
						state_q <= S_AET;
					end
					S_AET: begin
						aet_q <= tmp_pkg::q_div(div_num_q);
						cet_q <= tmp_pkg::q_div(div_num_q);
						state_q <= S_T1;
					end
					S_T1: begin
						tmp_q <= 64'(tmp_pkg::q_mul(mul_acc_q));
						state_q <= S_AEPT;
					end
					S_AEPT: begin
						aep_q <= tmp_pkg::q_mul(mul_acc_q) >> 1;
						cep_q <= tmp_pkg::q_mul(mul_acc_q) >> 1;
						state_q <= S_DT3T;
					end
					S_DT3T: begin
						dt3_q <= tmp_pkg::q_div(div_num_q);
						state_q <= S_CLAMP;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign plan.aet = aet_q;
	assign plan.cet = cet_q;
	assign plan.det = det_q;
	assign plan.aep = aep_q[31:0];
	assign plan.cep = cep_q[31:0];
	assign plan.peak = peak_q;

endmodule

// ===== src/trapezoid_motion_profile_top.sv =====
// The valid flag runs through v_s1, v_s2, v_s3, v_s4 and done_q; done rises with the registered position and phase.
// Throughput: one item per cycle while busy is low; the sample path is a five-register pipeline.
// After reset and after every configuration write, busy stays high while the plan is rebuilt
// on a shared serial divider, multiplier and square root unit.
// Reset clears the pipeline, loads the register defaults and starts planning at once.
// The receiver cannot stall, so done is never held off.
module trapezoid_motion_profile_top #(
	parameter int WORD_WIDTH = tmp_pkg::WORD_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] sample_time,
	output logic done,
	output logic signed [WORD_WIDTH-1:0] position,
	output logic [1:0] phase,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int MW = tmp_pkg::MAG_W;
	localparam int QW = tmp_pkg::MQ_W;
	localparam int FB = tmp_pkg::FRAC_BITS;
	localparam int FW = QW + 32;
	localparam logic [63:0] LIM = 64'd1 << (WORD_WIDTH - 1);

	logic [30:0] max_velocity_q, accel_rate_q;
	logic [31:0] decel_rate_q, target_distance_q;
	logic cfg_wr, accept;
	logic [31:0] dec_abs;
	tmp_pkg::cfg_t cfg;
	tmp_pkg::plan_t plan;

	logic v_s1, v_s2, v_s3, v_s4, done_q;
	tmp_pkg::phase_t ph_in, ph_s1, ph_s2, ph_s3, ph_s4;
	logic [31:0] x_in, coef_in, x_s1, coef_s1, x_s2;
	logic [MW-1:0] t_ext;
	logic [63:0] prod_c, lin_c;
	logic [QW-1:0] mq_s2, lin_s2;
	logic [63:0] lo_s3;
	logic [QW-1:0] hi_s3;
	logic [QW:0] up_s3, up_s4;
	logic [31:0] base;
	logic [FW-1:0] full;
	logic [FW-FB-1:0] qp;
	logic [MW-1:0] quad_s4, quad_sat;
	logic [63:0] pm, neg_pm;
	logic [WORD_WIDTH-1:0] pos_n, position_q;
	logic [1:0] phase_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_velocity_q <= 31'd65536;
			accel_rate_q <= 31'd65536;
			decel_rate_q <= 32'hFFFF0000;
			target_distance_q <= '0;
		end else if (cfg_wr) begin
			case (tmp_pkg::reg_idx_t'(cfg_index))
				tmp_pkg::REG_MAX_VELOCITY: max_velocity_q <= cfg_data[30:0];
				tmp_pkg::REG_ACCEL_RATE: accel_rate_q <= cfg_data[30:0];
				tmp_pkg::REG_DECEL_RATE: decel_rate_q <= cfg_data;
				tmp_pkg::REG_TARGET_DISTANCE: target_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dec_abs = decel_rate_q[31] ? -decel_rate_q : decel_rate_q;
	assign cfg.v = (max_velocity_q == '0) ? 31'd1 : max_velocity_q;
	assign cfg.a = (accel_rate_q == '0) ? 31'd1 : accel_rate_q;
	assign cfg.d = (dec_abs == '0) ? 32'd1 : dec_abs;
	assign cfg.s = target_distance_q[31] ? -target_distance_q : target_distance_q;

	tmp_plan u_plan (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_wr),
		.cfg(cfg),
		.plan(plan),
		.busy(busy)
	);

	assign t_ext = MW'(sample_time);

	always_comb begin
		if (t_ext < plan.aet) begin
			ph_in = tmp_pkg::PH_ACCEL;
		end else if (t_ext < plan.cet) begin
			ph_in = tmp_pkg::PH_CRUISE;
		end else if (t_ext < plan.det) begin
			ph_in = tmp_pkg::PH_DECEL;
		end else begin
			ph_in = tmp_pkg::PH_DONE;
		end
		case (ph_in)
			tmp_pkg::PH_ACCEL: x_in = sample_time;
			tmp_pkg::PH_CRUISE: x_in = sample_time - plan.aet[31:0];
			tmp_pkg::PH_DECEL: x_in = sample_time - plan.cet[31:0];
			default: x_in = '0;
		endcase
		coef_in = (ph_in == tmp_pkg::PH_DECEL) ? cfg.d : 32'(cfg.a);
	end

	assign prod_c = 64'(coef_s1) * 64'(x_s1);
	assign lin_c = 64'(plan.peak) * 64'(x_s1);
	assign base = (ph_s2 == tmp_pkg::PH_CRUISE) ? plan.aep : plan.cep;
	assign full = FW'(lo_s3) + {hi_s3, 32'd0};
	assign qp = full[FW-1:FB];
	assign quad_sat = (qp > (FW-FB)'(tmp_pkg::CEIL_MAG)) ? tmp_pkg::CEIL_MAG : qp[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= ph_in;
		x_s1 <= x_in;
		coef_s1 <= coef_in;
		ph_s2 <= ph_s1;
		x_s2 <= x_s1;
		mq_s2 <= prod_c[63:FB];
		lin_s2 <= lin_c[63:FB];
		ph_s3 <= ph_s2;
		lo_s3 <= 64'(mq_s2[31:0]) * 64'(x_s2);
		hi_s3 <= QW'(mq_s2[QW-1:32]) * QW'(x_s2);
		up_s3 <= (QW+1)'(base) + (QW+1)'(lin_s2);
		ph_s4 <= ph_s3;
		up_s4 <= up_s3;
		quad_s4 <= quad_sat >> 1;
		position_q <= pos_n;
		phase_q <= ph_s4;
	end

	always_comb begin
		case (ph_s4)
			tmp_pkg::PH_ACCEL: pm = 64'(quad_s4);
			tmp_pkg::PH_CRUISE: pm = 64'(up_s4);
			tmp_pkg::PH_DECEL: pm = (64'(up_s4) > 64'(quad_s4)) ?
				64'(up_s4) - 64'(quad_s4) : 64'd0;
			default: pm = 64'(cfg.s);
		endcase
		neg_pm = -pm;
		if (!target_distance_q[31]) begin
			pos_n = (pm >= LIM) ? WORD_WIDTH'(LIM - 64'd1) : WORD_WIDTH'(pm);
		end else begin
			pos_n = (pm > LIM) ? WORD_WIDTH'(LIM) : WORD_WIDTH'(neg_pm);
		end
	end

	assign done = done_q;
	assign position = position_q;
	assign phase = phase_q;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("pipeline lost an item between stages one and two");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result strobe without an accepted item");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !target_distance_q[31]) |-> !position[WORD_WIDTH-1])
		else $error("forward move produced a negative position");

	a_done_target: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (phase == tmp_pkg::PH_DONE) && (target_distance_q == 32'd0))
		|-> (position == '0))
		else $error("finished zero move not at origin");

endmodule
